// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers, clocked on clk and held off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds at every edge
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// a implies b in the same cycle
`define ASSERT_IMPL(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// a implies b in the next cycle
`define ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/abrw_pkg.sv =====
package abrw_pkg;

  localparam int TABLE_ENTRIES_DEF = 128;
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd1;

  localparam logic [7:0] THRESHOLD_RESET = 8'd10;
  localparam logic [15:0] WINDOW_RESET = 16'd20;

  typedef enum logic [1:0] {
    ST_NEW = 2'd0,
    ST_UPDATED = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } eng_state_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    logic [31:0] key_ip;
    logic [47:0] mac;
    logic [7:0]  count;
    logic [31:0] wstart;
    logic        blocked;
  } entry_t;

  typedef struct packed {
    status_t     status;
    logic [6:0]  entry_index;
    logic        mac_changed;
    logic [47:0] previous_mac;
    logic [7:0]  hit_count;
    logic        block_alert;
  } result_t;

  typedef struct packed {
    logic [7:0]  threshold;
    logic [15:0] window;
  } cfg_t;

endpackage

// ===== hw/rtl/abrw_queue.sv =====
module abrw_queue #(
  parameter int DEPTH = abrw_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  abrw_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output abrw_pkg::item_t head
);

  `include "assert_macros.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  abrw_pkg::item_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == DEPTH_CNT);
  assign not_empty = (count != '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= DEPTH_CNT)
  `ASSERT_IMPL(a_no_pop_empty, pop, count != '0)
  `ASSERT_IMPL(a_no_push_full, push && !pop, count != DEPTH_CNT)

endmodule

// ===== hw/rtl/abrw_engine.sv =====
module abrw_engine #(
  parameter int TABLE_ENTRIES = abrw_pkg::TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  abrw_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  abrw_pkg::item_t   q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output abrw_pkg::result_t res
);

  `include "assert_macros.svh"

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] TABLE_CNT = CNT_W'(TABLE_ENTRIES);

  abrw_pkg::eng_state_t state, state_next;

  abrw_pkg::entry_t mem [TABLE_ENTRIES];
  abrw_pkg::entry_t rd_data;
  abrw_pkg::entry_t hit_ent;
  abrw_pkg::entry_t wr_data;
  abrw_pkg::item_t  cur;
  abrw_pkg::result_t res_next;

  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] scan_idx;
  logic             chk_valid;
  logic [IDX_W-1:0] chk_idx;
  logic             hit_flag;
  logic [IDX_W-1:0] hit_idx;

  logic             issue;
  logic             match;
  logic             upd_go;
  logic             room;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;

  logic [31:0]      age;
  logic             win_open;
  logic [7:0]       cnt_new;
  logic [31:0]      ws_new;
  logic             alert;
  logic [IDX_W+6:0] hit_ext;
  logic [IDX_W+6:0] new_ext;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      abrw_pkg::S_IDLE: begin
        if (q_valid) begin
          state_next = abrw_pkg::S_SCAN;
        end
      end
      abrw_pkg::S_SCAN: begin
        if (match || !issue) begin
          state_next = abrw_pkg::S_UPDATE;
        end
      end
      abrw_pkg::S_UPDATE: begin
        if (upd_go) begin
          state_next = abrw_pkg::S_IDLE;
        end
      end
      default: state_next = abrw_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop = 1'b0;
    issue = 1'b0;
    upd_go = 1'b0;
    unique case (state)
      abrw_pkg::S_IDLE:   q_pop = q_valid;
      abrw_pkg::S_SCAN:   issue = (scan_idx < used);
      abrw_pkg::S_UPDATE: upd_go = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign match = (state == abrw_pkg::S_SCAN) && chk_valid && (rd_data.key_ip == cur.ip);
  assign room = (used < TABLE_CNT);

  // entry update
  assign age = cur.now - hit_ent.wstart;
  assign win_open = (age <= {16'd0, cfg.window});
  assign cnt_new = !win_open ? 8'd1 :
                   (hit_ent.count == 8'hFF) ? hit_ent.count : hit_ent.count + 8'd1;
  assign ws_new = win_open ? hit_ent.wstart : cur.now;
  assign alert = (cnt_new >= cfg.threshold) && !hit_ent.blocked;
  assign hit_ext = {7'd0, hit_idx};
  assign new_ext = {7'd0, used[IDX_W-1:0]};

  always_comb begin
    wr_en = 1'b0;
    wr_addr = hit_idx;
    wr_data = hit_ent;
    res_next = '0;
    res_next.status = abrw_pkg::ST_FULL;
    if (hit_flag) begin
      wr_en = upd_go;
      wr_data.mac = cur.mac;
      wr_data.count = cnt_new;
      wr_data.wstart = ws_new;
      wr_data.blocked = hit_ent.blocked | alert;
      res_next.status = abrw_pkg::ST_UPDATED;
      res_next.entry_index = hit_ext[6:0];
      res_next.mac_changed = (hit_ent.mac != cur.mac);
      res_next.previous_mac = hit_ent.mac;
      res_next.hit_count = cnt_new;
      res_next.block_alert = alert;
    end else if (room) begin
      wr_en = upd_go;
      wr_addr = used[IDX_W-1:0];
      wr_data.key_ip = cur.ip;
      wr_data.mac = cur.mac;
      wr_data.count = 8'd1;
      wr_data.wstart = cur.now;
      wr_data.blocked = 1'b0;
      res_next.status = abrw_pkg::ST_NEW;
      res_next.entry_index = new_ext[6:0];
      res_next.hit_count = 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data <= mem[scan_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    chk_idx <= scan_idx[IDX_W-1:0];
    if (match) begin
      hit_idx <= chk_idx;
      hit_ent <= rd_data;
    end
    if (upd_go) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abrw_pkg::S_IDLE;
      used <= '0;
      scan_idx <= '0;
      chk_valid <= 1'b0;
      hit_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      chk_valid <= issue;
      if (q_pop) begin
        scan_idx <= '0;
        hit_flag <= 1'b0;
      end else if (issue) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (match) begin
        hit_flag <= 1'b1;
      end
      if (upd_go && !hit_flag && room) begin
        used <= used + 1'b1;
      end
      if (upd_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_ALWAYS(a_used_bound, used <= TABLE_CNT)
  `ASSERT_IMPL(a_alert_on_hit, out_valid && res.block_alert, res.status == abrw_pkg::ST_UPDATED)
  `ASSERT_NEXT(a_append_grows, upd_go && !hit_flag && room, used == $past(used) + 1'b1)
  `ASSERT_IMPL(a_full_only_when_full, upd_go && !hit_flag, room || used == TABLE_CNT)

endmodule

// ===== hw/rtl/arp_binding_rate_watch_table.sv =====
// ARP binding watch table.
// Input channel (in_valid/in_ready): one item per ARP packet carrying
// src_ip, src_mac and now_seconds. A two-item queue takes items
// while the lookup engine is busy; in_ready drops only when it is full.
// Output channel (out_valid/out_ready): exactly one result per item, in
// order: status, entry_index, mac_changed, previous_mac, hit_count,
// block_alert. The result sits in an output register; while the receiver
// stalls, the engine holds its next result and the queue keeps accepting.
// The engine takes one item at a time: it scans the table until a match or
// the last used slot, reading one table slot per cycle through the single
// read port of the binding memory, then writes the result before it pops
// the next item.
// cfg_we/cfg_index/cfg_data write alert_threshold (index 0) and
// window_seconds (index 1); other indexes are ignored.
// Reset empties the queue and the table and loads threshold 10 and
// window 20 seconds; table contents are not cleared.
module arp_binding_rate_watch_table #(
  parameter int TABLE_ENTRIES = abrw_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [abrw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [abrw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [31:0]                    src_ip,
  input  logic [47:0]                    src_mac,
  input  logic [31:0]                    now_seconds,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     status,
  output logic [6:0]                     entry_index,
  output logic                           mac_changed,
  output logic [47:0]                    previous_mac,
  output logic [7:0]                     hit_count,
  output logic                           block_alert
);

  abrw_pkg::cfg_t    cfg;
  abrw_pkg::item_t   in_item;
  abrw_pkg::item_t   q_item;
  abrw_pkg::result_t res;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= abrw_pkg::THRESHOLD_RESET;
      cfg.window <= abrw_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      if (cfg_index == abrw_pkg::REG_THRESHOLD) begin
        cfg.threshold <= cfg_data[7:0];
      end else if (cfg_index == abrw_pkg::REG_WINDOW) begin
        cfg.window <= cfg_data[15:0];
      end
    end
  end

  assign in_item.ip = src_ip;
  assign in_item.mac = src_mac;
  assign in_item.now = now_seconds;
  assign in_ready = !q_full;

  abrw_queue #(
    .DEPTH(abrw_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(in_valid && in_ready),
    .push_item(in_item),
    .full(q_full),
    .pop(q_pop),
    .not_empty(q_valid),
    .head(q_item)
  );

  abrw_engine #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_engine (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .q_valid(q_valid),
    .q_item(q_item),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .res(res)
  );

  assign status = res.status;
  assign entry_index = res.entry_index;
  assign mac_changed = res.mac_changed;
  assign previous_mac = res.previous_mac;
  assign hit_count = res.hit_count;
  assign block_alert = res.block_alert;

endmodule

// ===== test/abrw_checker.sv =====
module abrw_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [abrw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [abrw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [31:0]                    src_ip,
  input  logic [47:0]                    src_mac,
  input  logic [31:0]                    now_seconds,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [1:0]                     status,
  input  logic [6:0]                     entry_index,
  input  logic                           mac_changed,
  input  logic [47:0]                    previous_mac,
  input  logic [7:0]                     hit_count,
  input  logic                           block_alert,
  output int                             mismatches,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS = abrw_pkg::TABLE_ENTRIES_DEF;

  logic [7:0]  thr_reg;
  logic [15:0] win_reg;
  int          slots_used;
  logic [31:0] bind_ip    [TABLE_SLOTS];
  logic [47:0] bind_mac   [TABLE_SLOTS];
  logic [7:0]  bind_count [TABLE_SLOTS];
  logic [31:0] bind_start [TABLE_SLOTS];
  logic        bind_block [TABLE_SLOTS];
  abrw_pkg::result_t binding_q[$];

  function automatic abrw_pkg::result_t track_binding(logic [31:0] ip, logic [47:0] mac,
                                                      logic [31:0] now);
    abrw_pkg::result_t r;
    logic [31:0]       age;
    int                slot;
    r = '0;
    r.status = abrw_pkg::ST_FULL;
    slot = -1;
    for (int i = 0; i < slots_used; i++) begin
      if (slot < 0 && bind_ip[i] == ip) slot = i;
    end
    if (slot >= 0) begin
      r.status = abrw_pkg::ST_UPDATED;
      r.entry_index = slot[6:0];
      r.previous_mac = bind_mac[slot];
      r.mac_changed = (bind_mac[slot] != mac);
      bind_mac[slot] = mac;
      age = now - bind_start[slot];
      if (age <= {16'd0, win_reg}) begin
        if (bind_count[slot] != 8'hFF) bind_count[slot] = bind_count[slot] + 8'd1;
      end else begin
        bind_count[slot] = 8'd1;
        bind_start[slot] = now;
      end
      if (bind_count[slot] >= thr_reg && !bind_block[slot]) begin
        bind_block[slot] = 1'b1;
        r.block_alert = 1'b1;
      end
      r.hit_count = bind_count[slot];
    end else if (slots_used < TABLE_SLOTS) begin
      bind_ip[slots_used] = ip;
      bind_mac[slots_used] = mac;
      bind_count[slots_used] = 8'd1;
      bind_start[slots_used] = now;
      bind_block[slots_used] = 1'b0;
      r.status = abrw_pkg::ST_NEW;
      r.entry_index = slots_used[6:0];
      r.hit_count = 8'd1;
      slots_used++;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    abrw_pkg::result_t want;
    if (rst) begin
      thr_reg <= abrw_pkg::THRESHOLD_RESET;
      win_reg <= abrw_pkg::WINDOW_RESET;
      slots_used = 0;
      binding_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == abrw_pkg::REG_THRESHOLD) thr_reg <= cfg_data[7:0];
        else if (cfg_index == abrw_pkg::REG_WINDOW) win_reg <= cfg_data;
      end
      if (out_valid && out_ready) begin
        if (binding_q.size() == 0) begin
          if (mismatches < 10)
            $display("%t: unexpected result status=%0d index=%0d", $realtime, status,
                     entry_index);
          mismatches <= mismatches + 1;
        end else begin
          want = binding_q.pop_front();
          if (want.status != status || want.entry_index != entry_index ||
              want.mac_changed != mac_changed || want.previous_mac != previous_mac ||
              want.hit_count != hit_count || want.block_alert != block_alert) begin
            if (mismatches < 10) begin
              $display("%t: mismatch exp st=%0d idx=%0d chg=%0d prev=%h cnt=%0d alert=%0d",
                       $realtime, want.status, want.entry_index, want.mac_changed,
                       want.previous_mac, want.hit_count, want.block_alert);
              $display("  got st=%0d idx=%0d chg=%0d prev=%h cnt=%0d alert=%0d",
                       status, entry_index, mac_changed, previous_mac, hit_count,
                       block_alert);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && in_ready)
        binding_q.push_back(track_binding(src_ip, src_mac, now_seconds));
      pending <= binding_q.size();
    end
  end
endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS = abrw_pkg::TABLE_ENTRIES_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [abrw_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [abrw_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [abrw_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [abrw_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [31:0]                     src_ip = '0;
  logic [47:0]                     src_mac = '0;
  logic [31:0]                     now_seconds = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [1:0]                      status;
  logic [6:0]                      entry_index;
  logic                            mac_changed;
  logic [47:0]                     previous_mac;
  logic [7:0]                      hit_count;
  logic                            block_alert;
  int                              mismatches;
  int                              pending;

  int          gap_max = 9;
  int          stall_max = 9;
  logic [31:0] sim_clock_s = 32'hFFFF_FF00;
  logic [31:0] pool_ip[$];
  logic [47:0] pool_mac[$];

  arp_binding_rate_watch_table u_top (.*);

  abrw_checker u_check (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [47:0] rand_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  task automatic send_packet(input logic [31:0] ip, input logic [47:0] mac,
                             input logic [31:0] now);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    src_ip <= ip;
    src_mac <= mac;
    now_seconds <= now;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the sender until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_regs(input logic [15:0] thr_data, input logic [15:0] win_data,
                            input logic [15:0] junk);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= abrw_pkg::REG_THRESHOLD;
    cfg_data <= thr_data;
    @(posedge clk);
    cfg_index <= abrw_pkg::REG_WINDOW;
    cfg_data <= win_data;
    @(posedge clk);
    cfg_index <= REG_SPARE_A;
    cfg_data <= junk;
    @(posedge clk);
    cfg_index <= REG_SPARE_B;
    cfg_data <= ~junk;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input logic [7:0] thr, input logic [15:0] win);
    write_regs({8'($urandom), thr}, win, 16'($urandom));
  endtask

  task automatic add_binding();
    pool_ip.push_back($urandom);
    pool_mac.push_back(rand_mac());
    sim_clock_s += 1;
    send_packet(pool_ip[$], pool_mac[$], sim_clock_s);
  endtask

  task automatic run_traffic(input int n);
    int sent;
    int r;
    int pick;
    int len;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 15 || pool_ip.size() == 0) begin
        add_binding();
        sent++;
      end else if (r < 85) begin
        // burst on one binding, mostly inside its window
        pick = $urandom_range(0, pool_ip.size() - 1);
        len = $urandom_range(1, 20);
        repeat (len) begin
          if ($urandom_range(0, 9) == 0) pool_mac[pick] = rand_mac();
          sim_clock_s += $urandom_range(0, 3);
          if ($urandom_range(0, 14) == 0) sim_clock_s += $urandom_range(0, 80);
          send_packet(pool_ip[pick], pool_mac[pick], sim_clock_s);
          sent++;
        end
      end else if (r < 95) begin
        send_packet($urandom, rand_mac(), $urandom);
        sent++;
      end else begin
        // clock steps back
        pick = $urandom_range(0, pool_ip.size() - 1);
        sim_clock_s -= $urandom_range(1, 1000);
        send_packet(pool_ip[pick], pool_mac[pick], sim_clock_s);
        sent++;
      end
    end
  endtask

  initial begin
    do @(posedge clk); while (rst);
    forever begin
      int w;
      w = $urandom_range(0, stall_max);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    logic [7:0]  thr;
    logic [15:0] win;
    logic [31:0] sat_ip;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // default threshold and window
    send_packet(32'h0, 48'h0, 32'h0);
    send_packet(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_packet(32'h0, 48'h0, 32'd20);                 // window edge, still open
    send_packet(32'h0, 48'hFFFF_FFFF_FFFF, 32'd20);    // mac change
    send_packet(32'h0, 48'hFFFF_FFFF_FFFF, 32'd41);    // window closed
    send_packet(32'hFFFF_FFFF, 48'h0, 32'd3);          // age wraps
    send_packet(32'h0, 48'hFFFF_FFFF_FFFF, 32'd40);    // clock steps back
    repeat (10) send_packet(32'h0, 48'hFFFF_FFFF_FFFF, 32'd40);  // alert once at 10

    set_regs(8'd1, 16'd0);
    send_packet(32'h1234_5678, 48'h5A5A_5A5A_5A5A, 32'd100);  // new entry, no alert
    send_packet(32'h1234_5678, 48'h5A5A_5A5A_5A5A, 32'd100);
    send_packet(32'hFFFF_FFFF, 48'h0, 32'd4);

    set_regs(8'd0, 16'hFFFF);
    send_packet(32'h0A00_0001, 48'hA5A5_A5A5_A5A5, 32'd7);
    send_packet(32'h0A00_0001, 48'hA5A5_A5A5_A5A5, 32'd7);
    send_packet(32'hFFFF_FFFF, 48'h0, 32'd60004);

    // saturation run, no idling
    set_regs(8'd255, 16'hFFFF);
    gap_max = 0;
    stall_max = 0;
    sat_ip = $urandom;
    send_packet(sat_ip, 48'h0000_1111_2222, sim_clock_s);
    repeat (259) send_packet(sat_ip, 48'h0000_1111_2222, sim_clock_s);

    for (int phase = 0; phase < 10; phase++) begin
      unique case (phase)
        0: begin
          thr = 8'd1;
          win = 16'd0;
        end
        1: begin
          thr = 8'd255;
          win = 16'hFFFF;
        end
        2: begin
          thr = 8'd0;
          win = 16'd1;
        end
        default: begin
          thr = $urandom_range(1, 30);
          win = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
        end
      endcase
      set_regs(thr, win);
      gap_max = (phase % 4 == 3) ? 0 : 9;
      stall_max = gap_max;
      if (phase == 4) repeat (TABLE_SLOTS + 12) add_binding();
      run_traffic(85);
    end

    drain();
    repeat (TABLE_SLOTS + 8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
